// File: src/tmtw_pkg.sv
// Shared constants, types and state codes for the text-mode terminal writer.
package tmtw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CELL_W  = 16;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int IDX_W   = 11;
    localparam int CNT_W   = 3;

    localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] CELLS_M1 = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_A = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_END_A = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LAST = COL_W'(COLUMNS - 1);

    localparam logic [7:0] CH_NEWLINE  = 8'd10;
    localparam logic [7:0] CH_TAB      = 8'd9;
    localparam logic [7:0] CH_BLANK    = 8'h20;
    localparam logic [7:0] RESET_COLOR = 8'h0D;
    localparam logic [CNT_W-1:0] TAB_WIDTH = CNT_W'(4);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDATA,
        ST_PUT,
        ST_COPY,
        ST_DRAIN,
        ST_FILL
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CELL_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic              done;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [CELL_W-1:0] read_cell;
        logic              scrolled;
    } res_t;

endpackage

// File: src/tmtw_screen_ram.sv
// Screen cell store: one write port, one registered read port.
module tmtw_screen_ram
    import tmtw_pkg::*;
(
    input  logic              clk,
    input  ram_req_t          req,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] screen_mem [CELLS];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            screen_mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= screen_mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/tmtw_ctrl.sv
// Command sequencer: cursor, put/newline/tab handling, scroll copy and clear sweeps.
module tmtw_ctrl
    import tmtw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              cmd,
    input  logic [7:0]        char_code,
    input  logic [IDX_W-1:0]  read_index,
    input  logic [7:0]        color,
    input  logic [CELL_W-1:0] rdata,
    output ram_req_t          req,
    output res_t              res,
    output logic              busy
);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [7:0]          ch_reg, ch_next;
    logic                rin_reg, rin_next;
    logic [CELL_W-1:0]   read_cell_reg, read_cell_next;
    logic                scrolled_reg, scrolled_next;
    logic                done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            scan_reg     <= '0;
            pend_reg     <= 1'b0;
            row_reg      <= '0;
            col_reg      <= '0;
            addr_reg     <= '0;
            cnt_reg      <= '0;
            scrolled_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_reg     <= scan_next;
            pend_reg     <= pend_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            addr_reg     <= addr_next;
            cnt_reg      <= cnt_next;
            scrolled_reg <= scrolled_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        ch_reg        <= ch_next;
        rin_reg       <= rin_next;
        read_cell_reg <= read_cell_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        ch_next        = ch_reg;
        rin_next       = rin_reg;
        read_cell_next = read_cell_reg;
        scrolled_next  = scrolled_reg;
        done_next      = 1'b0;

        // copy write lands in the cycle after its read
        req.we    = pend_reg;
        req.waddr = pend_addr_reg;
        req.wdata = rdata;
        req.re    = 1'b0;
        req.raddr = scan_reg + COLS_A;

        case (state_reg)
            ST_CLEAR:
            begin
                req.we    = 1'b1;
                req.waddr = scan_reg;
                req.wdata = {RESET_COLOR, CH_BLANK};
                if (scan_reg == CELLS_M1)
                begin
                    scan_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (start && !done_reg)
                begin
                    scrolled_next  = 1'b0;
                    read_cell_next = '0;
                    if (cmd)
                    begin
                        req.re     = 1'b1;
                        req.raddr  = ADDR_W'(read_index);
                        rin_next   = (32'(read_index) < CELLS);
                        state_next = ST_RDATA;
                    end
                    else if (char_code == CH_NEWLINE)
                    begin
                        col_next = '0;
                        cnt_next = '0;
                        if (row_reg == ROW_LAST)
                        begin
                            scrolled_next = 1'b1;
                            scan_next     = '0;
                            state_next    = ST_COPY;
                        end
                        else
                        begin
                            row_next  = row_reg + 1'b1;
                            addr_next = addr_reg - ADDR_W'(col_reg) + COLS_A;
                            done_next = 1'b1;
                        end
                    end
                    else if (char_code == CH_TAB)
                    begin
                        ch_next    = CH_BLANK;
                        cnt_next   = TAB_WIDTH;
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        ch_next    = char_code;
                        cnt_next   = CNT_W'(1);
                        state_next = ST_PUT;
                    end
                end
            end

            ST_RDATA:
            begin
                read_cell_next = rin_reg ? rdata : '0;
                done_next      = 1'b1;
                state_next     = ST_IDLE;
            end

            ST_PUT:
            begin
                req.we    = 1'b1;
                req.waddr = addr_reg;
                req.wdata = {color, ch_reg};
                cnt_next  = cnt_reg - 1'b1;
                if (col_reg == COL_LAST)
                begin
                    col_next = '0;
                    if (row_reg == ROW_LAST)
                    begin
                        scrolled_next = 1'b1;
                        scan_next     = '0;
                        state_next    = ST_COPY;
                    end
                    else
                    begin
                        row_next  = row_reg + 1'b1;
                        addr_next = addr_reg + 1'b1;
                        if (cnt_reg == CNT_W'(1))
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    col_next  = col_reg + 1'b1;
                    addr_next = addr_reg + 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_COPY:
            begin
                req.re         = 1'b1;
                pend_next      = 1'b1;
                pend_addr_next = scan_reg;
                if (scan_reg == COPY_END_A)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                scan_next  = LAST_ROW_A;
                state_next = ST_FILL;
            end

            ST_FILL:
            begin
                req.we    = 1'b1;
                req.waddr = scan_reg;
                req.wdata = {color, CH_BLANK};
                if (scan_reg == CELLS_M1)
                begin
                    scan_next = '0;
                    row_next  = ROW_LAST;
                    addr_next = LAST_ROW_A;
                    if (cnt_reg != '0)
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != ST_IDLE) || done_reg;
    assign res.done       = done_reg;
    assign res.cursor_row = row_reg;
    assign res.cursor_col = col_reg;
    assign res.read_cell  = read_cell_reg;
    assign res.scrolled   = scrolled_reg;

endmodule

// File: src/text_mode_terminal_writer_core.sv
// Top level of the text-mode terminal writer: color register, sequencer and screen store.
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------------
//  command   | start, busy        | cmd, char_code, read_index
//  result    | done (1-cycle)     | cursor_row, cursor_col, read_cell, scrolled
//  config    | text_color_we      | text_color
//
// A command transfers at a clock edge where start is high and busy is low.
// Read: the store's registered read, then ST_RDATA latches the cell and raises the done
// strobe. Plain put: one write in ST_PUT; newline without scroll: done straight from idle;
// tab: TAB_WIDTH blank cells in ST_PUT, one store write per written cell.
// A scroll walks the store one cell a cycle through the single read/write pair: ST_COPY
// moves rows up, ST_DRAIN lands the last write, ST_FILL blanks the bottom row.
// After reset the store is swept to blank cells in color 0x0D, and busy stays high
// for the whole sweep. Color writes are taken at any time.
// The receiver cannot stall: done marks each result, and the payload is held only until the next command transfers.
module text_mode_terminal_writer_core
    import tmtw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cmd,
    input  logic [7:0]        char_code,
    input  logic [IDX_W-1:0]  read_index,
    input  logic              text_color_we,
    input  logic [7:0]        text_color,
    output logic              done,
    output logic [ROW_W-1:0]  cursor_row,
    output logic [COL_W-1:0]  cursor_col,
    output logic [CELL_W-1:0] read_cell,
    output logic              scrolled
);

    logic [7:0]        color_reg;
    logic [CELL_W-1:0] rdata;
    ram_req_t          req;
    res_t              res;

    // hold the attribute byte used for every new cell and scroll fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= RESET_COLOR;
        end
        else if (text_color_we)
        begin
            color_reg <= text_color;
        end
    end

    // sequencer: owns the cursor and drives every access to the store
    tmtw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .char_code  (char_code),
        .read_index (read_index),
        .color      (color_reg),
        .rdata      (rdata),
        .req        (req),
        .res        (res),
        .busy       (busy)
    );

    // screen store, read data registered and valid in the cycle after the request
    tmtw_screen_ram u_ram (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    assign done       = res.done;
    assign cursor_row = res.cursor_row;
    assign cursor_col = res.cursor_col;
    assign read_cell  = res.read_cell;
    assign scrolled   = res.scrolled;

    // a transferred command always keeps the block busy for the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command transfer not followed by busy");

    // results never come back to back
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    // a scroll leaves the cursor on the bottom row
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        done && scrolled |-> cursor_row == ROW_LAST)
        else $error("scroll left cursor off the bottom row");

    // the cursor stays on the screen
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(cursor_row) < ROWS) && (32'(cursor_col) < COLUMNS))
        else $error("cursor outside the screen");

endmodule

// File: test/text_mode_terminal_writer_checker.sv
// Command codes, result record and the console predictor/scoreboard for the terminal writer.
package tmtw_check_pkg;

    typedef enum logic {
        OP_PUT  = 1'b0,
        OP_READ = 1'b1
    } console_op_t;

    typedef struct packed {
        logic [tmtw_pkg::ROW_W-1:0]  row;
        logic [tmtw_pkg::COL_W-1:0]  col;
        logic [tmtw_pkg::CELL_W-1:0] cell_data;
        logic                        scrolled;
    } console_result_t;

endpackage

module text_mode_terminal_writer_checker
    import tmtw_pkg::*;
    import tmtw_check_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              cmd,
    input  logic [7:0]        char_code,
    input  logic [IDX_W-1:0]  read_index,
    input  logic              text_color_we,
    input  logic [7:0]        text_color,
    input  logic              done,
    input  logic [ROW_W-1:0]  cursor_row,
    input  logic [COL_W-1:0]  cursor_col,
    input  logic [CELL_W-1:0] read_cell,
    input  logic              scrolled,
    output int                fail_count,
    output int                pending,
    output int                scroll_count,
    output int                result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_REPORTS = 100;

    logic [CELL_W-1:0] screen_mem [CELLS];
    int                cur_row;
    int                cur_col;
    logic [7:0]        attr;
    logic              scroll_flag;
    console_result_t   console_expected [$];
    int                report_count;

    function automatic void scroll_up();
        for (int i = 0; i < CELLS - COLUMNS; i++)
        begin
            screen_mem[i] = screen_mem[i + COLUMNS];
        end
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
        begin
            screen_mem[i] = {attr, CH_BLANK};
        end
        cur_row     = ROWS - 1;
        scroll_flag = 1'b1;
    endfunction

    function automatic void next_row();
        cur_row++;
        if (cur_row >= ROWS)
        begin
            scroll_up();
        end
    endfunction

    function automatic void write_and_advance(logic [7:0] ch);
        int pos;
        pos = cur_row * COLUMNS + cur_col;
        if (pos < CELLS)
        begin
            screen_mem[pos] = {attr, ch};
        end
        cur_col++;
        if (cur_col >= COLUMNS)
        begin
            cur_col = 0;
            next_row();
        end
    endfunction

    function automatic console_result_t predict_console(logic op, logic [7:0] ch,
                                                        logic [IDX_W-1:0] idx);
        console_result_t res;
        res         = '0;
        scroll_flag = 1'b0;
        if (op == OP_READ)
        begin
            if (idx < CELLS)
            begin
                res.cell_data = screen_mem[idx];
            end
        end
        else if (ch == CH_NEWLINE)
        begin
            next_row();
            cur_col = 0;
        end
        else if (ch == CH_TAB)
        begin
            for (int i = 0; i < TAB_WIDTH; i++)
            begin
                write_and_advance(CH_BLANK);
            end
        end
        else
        begin
            write_and_advance(ch);
        end
        res.row      = ROW_W'(cur_row);
        res.col      = COL_W'(cur_col);
        res.scrolled = scroll_flag;
        return res;
    endfunction

    function automatic void report_mismatch(string field, logic [CELL_W-1:0] want_v,
                                            logic [CELL_W-1:0] got_v);
        fail_count++;
        if (report_count < MAX_REPORTS)
        begin
            report_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        console_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                screen_mem[i] = {RESET_COLOR, CH_BLANK};
            end
            cur_row      = 0;
            cur_col      = 0;
            attr         = RESET_COLOR;
            scroll_flag  = 1'b0;
            console_expected.delete();
            fail_count   = 0;
            pending      = 0;
            scroll_count = 0;
            result_count = 0;
            report_count = 0;
        end
        else
        begin
            // Retire the oldest expectation before taking a new command at the same edge.
            if (done)
            begin
                result_count++;
                if (console_expected.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with no command outstanding, row %0d col %0d",
                             $time, cursor_row, cursor_col);
                end
                else
                begin
                    want = console_expected.pop_front();
                    if (want.scrolled)
                    begin
                        scroll_count++;
                    end
                    if (cursor_row !== want.row)
                        report_mismatch("cursor_row", want.row, cursor_row);
                    if (cursor_col !== want.col)
                        report_mismatch("cursor_col", want.col, cursor_col);
                    if (read_cell !== want.cell_data)
                        report_mismatch("read_cell", want.cell_data, read_cell);
                    if (scrolled !== want.scrolled)
                        report_mismatch("scrolled", want.scrolled, scrolled);
                end
            end
            if (text_color_we)
            begin
                attr = text_color;
            end
            if (start && !busy)
            begin
                console_expected.push_back(predict_console(cmd, char_code, read_index));
            end
            pending = console_expected.size();
        end
    end

endmodule

// File: test/text_mode_terminal_writer_core_test.sv
// Testbench top for the text-mode terminal writer: clock, reset, command stimulus and verdict.
module text_mode_terminal_writer_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tmtw_pkg::*;
    import tmtw_check_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 3;
    localparam int RANDOM_ITEMS = 930;
    localparam int COLOR_PHASES = 8;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / COLOR_PHASES;
    localparam int DRAIN_CYCLES = 20;
    // Worst case: the clearing sweep, then every command paying a full scroll plus
    // its own cycles and a sender gap; take that four times over.
    localparam int CYCLE_LIMIT  = 4 * (CELLS + (RANDOM_ITEMS + 200) * (CELLS + 20));

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              start         = 1'b0;
    logic              busy;
    logic              cmd           = 1'b0;
    logic [7:0]        char_code     = '0;
    logic [IDX_W-1:0]  read_index    = '0;
    logic              text_color_we = 1'b0;
    logic [7:0]        text_color    = '0;
    logic              done;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
    logic [CELL_W-1:0] read_cell;
    logic              scrolled;

    int fail_count;
    int pending;
    int scroll_count;
    int result_count;

    int cycle_count = 0;
    int sent_items  = 0;
    int read_items  = 0;
    int color_count = 0;
    int idle_pct    = 0;

    text_mode_terminal_writer_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .char_code    (char_code),
        .read_index   (read_index),
        .text_color_we(text_color_we),
        .text_color   (text_color),
        .done         (done),
        .cursor_row   (cursor_row),
        .cursor_col   (cursor_col),
        .read_cell    (read_cell),
        .scrolled     (scrolled)
    );

    text_mode_terminal_writer_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .char_code    (char_code),
        .read_index   (read_index),
        .text_color_we(text_color_we),
        .text_color   (text_color),
        .done         (done),
        .cursor_row   (cursor_row),
        .cursor_col   (cursor_col),
        .read_cell    (read_cell),
        .scrolled     (scrolled),
        .fail_count   (fail_count),
        .pending      (pending),
        .scroll_count (scroll_count),
        .result_count (result_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Any byte except the two control codes; those get their own picks.
    function automatic logic [7:0] plain_char();
        logic [7:0] ch;
        ch = 8'($urandom_range(0, 255));
        if (ch == CH_TAB || ch == CH_NEWLINE)
        begin
            ch = CH_BLANK;
        end
        return ch;
    endfunction

    // Drop start for an idle burst of random length; scramble the payload so the block must ignore it.
    task automatic idle_burst();
        int n;
        n = $urandom_range(1, 3);
        start      <= 1'b0;
        cmd        <= 1'($urandom_range(0, 1));
        char_code  <= 8'($urandom_range(0, 255));
        read_index <= IDX_W'($urandom_range(0, 2047));
        repeat (n) @(negedge clk);
    endtask

    // Present one command and hold it until the block takes the transfer.
    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(console_op_t op, logic [7:0] ch, logic [IDX_W-1:0] idx);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            idle_burst();
        end
        start      <= 1'b1;
        cmd        <= op;
        char_code  <= ch;
        read_index <= idx;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        sent_items++;
        if (op == OP_READ)
        begin
            read_items++;
        end
    endtask

    task automatic put_char(logic [7:0] ch);
        send_item(OP_PUT, ch, IDX_W'($urandom_range(0, 2047)));
    endtask

    task automatic read_at(logic [IDX_W-1:0] idx);
        send_item(OP_READ, 8'($urandom_range(0, 255)), idx);
    endtask

    // Hold the command side until every outstanding result has come back.
    task automatic wait_drained();
        start <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    // One-cycle color write; only issued while nothing is outstanding.
    task automatic set_color(logic [7:0] color);
        text_color_we <= 1'b1;
        text_color    <= color;
        @(negedge clk);
        text_color_we <= 1'b0;
        color_count++;
    endtask

    // A well-formed line: newline puts the cursor at column 0, so a run of
    // 74 to 80 characters leaves the tab starting at column 74 or later, or on the next line.
    // On the bottom row a wrap by the tab or by the 80th character scrolls the screen.
    task automatic line_run();
        int len;
        len = $urandom_range(74, 80);
        put_char(CH_NEWLINE);
        repeat (len) put_char(plain_char());
        put_char(CH_TAB);
    endtask

    task automatic random_pick();
        int sel;
        sel = $urandom_range(0, 199);
        if (sel < 3)
            line_run();
        else if (sel < 86)
            put_char(plain_char());
        else if (sel < 114)
            put_char(CH_NEWLINE);
        else if (sel < 130)
            put_char(CH_TAB);
        else if (sel < 140)
            // Bottom two rows and the out-of-range tail: the bottom row is freshly blanked after a scroll.
            read_at(IDX_W'($urandom_range(CELLS - 2 * COLUMNS, 2047)));
        else
            read_at(IDX_W'($urandom_range(0, 2047)));
    endtask

    initial
    begin
        logic [7:0] color;
        int         target;

        // Reset once; the block then sweeps the store and holds busy high meanwhile.
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, under the reset color: cleared cells, index extremes,
        // out-of-range reads, byte extremes, a stored control byte, tab and newline.
        idle_pct = 25;
        read_at('0);
        read_at(IDX_W'(CELLS - 1));
        read_at(IDX_W'(CELLS));
        read_at('1);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        put_char(8'h0D);
        put_char(CH_BLANK);
        put_char(CH_TAB);
        read_at(IDX_W'(0));
        read_at(IDX_W'(3));
        read_at(IDX_W'(5));
        read_at(IDX_W'(8));
        put_char(CH_NEWLINE);
        put_char(8'h7F);
        read_at(IDX_W'(COLUMNS));
        read_at(IDX_W'(1));

        // Random part in color phases; the first two take the register extremes.
        for (int p = 0; p < COLOR_PHASES; p++)
        begin
            wait_drained();
            if (p == 0)
                color = 8'h00;
            else if (p == 1)
                color = 8'hFF;
            else
                color = 8'($urandom_range(0, 255));
            set_color(color);
            // Some phases run back to back; the last one never idles.
            if (p == COLOR_PHASES - 1 || $urandom_range(0, 3) == 0)
                idle_pct = 0;
            else
                idle_pct = 30;
            target = sent_items + PHASE_ITEMS;
            while (sent_items < target)
            begin
                random_pick();
                if ($urandom_range(0, 49) == 0)
                begin
                    wait_drained();
                end
            end
        end

        // Let the last results arrive, then watch for strays.
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d commands (%0d reads) over %0d text colors after the reset color.",
                 sent_items, read_items, color_count);
        $display("Checked %0d results, %0d of them with a screen scroll.",
                 result_count, scroll_count);
        if (fail_count == 0 && pending == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived", fail_count, pending);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: files.f
src/tmtw_pkg.sv
src/tmtw_screen_ram.sv
src/tmtw_ctrl.sv
src/text_mode_terminal_writer_core.sv
test/text_mode_terminal_writer_checker.sv
test/text_mode_terminal_writer_core_test.sv
